[design/idre_pkg.sv]
// ----------------------------------------------------------------------------
// idre_pkg
// Shared types, constants and the feature view table for the ID register
// read emulation block.
// ----------------------------------------------------------------------------
package idre_pkg;

   localparam int unsigned InsnWidth  = 32;
   localparam int unsigned ValueWidth = 64;
   localparam int unsigned RegWidth   = 5;

   localparam logic [31:0] MRS_MASK   = 32'hfff0_0000;
   localparam logic [31:0] MRS_MATCH  = 32'hd530_0000;
   localparam logic [63:0] MPIDR_SAFE = 64'h0000_0000_8000_0000;

   // CRm codes of interest
   localparam logic [3:0] CRM_MAIN = 4'd0;
   localparam logic [3:0] CRM_RSVD = 4'd1;
   localparam logic [3:0] CRM_LAST = 4'd7;

   // op2 selectors within CRm 0
   localparam logic [2:0] OP2_MIDR   = 3'd0;
   localparam logic [2:0] OP2_MPIDR  = 3'd5;
   localparam logic [2:0] OP2_REVIDR = 3'd6;

   typedef struct packed {
      logic                  hit;
      logic [ValueWidth-1:0] show;
      logic [ValueWidth-1:0] safe;
   } view_type;

   typedef struct packed {
      logic                  handled;
      logic [RegWidth-1:0]   dest_reg;
      logic [ValueWidth-1:0] read_value;
   } result_type;

   // Visible-bit mask and hidden safe bits for the tracked slots in CRm 4..7.
   function automatic view_type view_lookup(input logic [2:0] crm, input logic [2:0] op2);
      view_type v;
      v.hit  = 1'b1;
      v.show = '0;
      v.safe = '0;
      unique case ({crm, op2})
         {3'd4, 3'd0}: begin
            v.show = 64'h000f_000f_00ff_0000;
            v.safe = 64'h0000_0000_0000_0011;
         end
         {3'd4, 3'd1}: v.show = 64'h0000_f000_0f00_0fff;
         {3'd4, 3'd2}: v.show = 64'h0000_000f_0000_0ff0;
         {3'd4, 3'd4}: v.show = 64'h0fff_ff0f_0fff_f0ff;
         {3'd4, 3'd5}: v.show = 64'hbff1_ffff_7381_0001;
         {3'd4, 3'd7}: v.show = 64'h0000_0000_fc00_8003;
         {3'd5, 3'd0}: v.safe = 64'h0000_0000_0000_0006;
         {3'd6, 3'd0}: v.show = 64'hf0ff_ffff_f0ff_fff0;
         {3'd6, 3'd1}: v.show = 64'hf0ff_f0ff_ffff_ffff;
         {3'd6, 3'd2}: v.show = 64'h0fff_0000_00ff_ffff;
         {3'd6, 3'd3}: v.show = 64'h0000_0000_f00f_00f0;
         {3'd7, 3'd0}: begin
            v.show = 64'hf000_0000_0000_0000;
            v.safe = 64'h0000_0111_ff00_0000;
         end
         {3'd7, 3'd1}: v.show = 64'h0000_f000_0000_0000;
         {3'd7, 3'd2}: v.show = 64'h0000_000f_0000_0000;
         {3'd7, 3'd3}: v.show = 64'h0000_0000_000f_0000;
         default:      v.hit  = 1'b0;
      endcase
      return v;
   endfunction

endpackage

[design/idre_decode.sv]
// ----------------------------------------------------------------------------
// idre_decode
// Decodes one instruction word as an MRS of the ID register space and forms
// the emulated register value from the raw ID value.
// ----------------------------------------------------------------------------
module idre_decode (
   input  logic [idre_pkg::InsnWidth-1:0]  insn_word,
   input  logic [idre_pkg::ValueWidth-1:0] raw_id_value,
   output idre_pkg::result_type            result
);
   import idre_pkg::*;

   logic       op0_hi;
   logic [2:0] op1;
   logic [3:0] crn;
   logic [3:0] crm;
   logic [2:0] op2;
   logic       in_space;
   view_type   view;

   assign op0_hi = insn_word[19];
   assign op1    = insn_word[18:16];
   assign crn    = insn_word[15:12];
   assign crm    = insn_word[11:8];
   assign op2    = insn_word[7:5];

   assign in_space = ((insn_word & MRS_MASK) == MRS_MATCH) && op0_hi && (op1 == 3'd0)
                     && (crn == 4'd0) && (crm != CRM_RSVD) && (crm <= CRM_LAST);

   assign view = view_lookup(crm[2:0], op2);

   always_comb begin
      result = '0;
      if (in_space) begin
         if (crm == CRM_MAIN) begin
            priority if (op2 == OP2_MIDR) begin
               result.handled    = 1'b1;
               result.read_value = raw_id_value;
            end else if (op2 == OP2_MPIDR) begin
               result.handled    = 1'b1;
               result.read_value = MPIDR_SAFE;
            end else if (op2 == OP2_REVIDR) begin
               result.handled    = 1'b1;
            end else begin
               // refuse any other CRm 0 selector
               result.handled    = 1'b0;
            end
         end else begin
            result.handled    = 1'b1;
            // untracked slots read as zero
            result.read_value = view.hit ? ((raw_id_value & view.show) | view.safe) : '0;
         end
         if (result.handled) begin
            result.dest_reg = insn_word[RegWidth-1:0];
         end
      end
   end

endmodule

[design/id_register_read_emulation.sv]
// ----------------------------------------------------------------------------
// id_register_read_emulation
// Emulates EL0 reads of the ID register space: one instruction word and raw
// ID value in, one handled flag, destination and value out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid/req_ready    insn_word, raw_id_value
//  rsp       out        rsp_valid/rsp_ready    handled, dest_reg, read_value
//
//  Two register stages: an input register, then the decode and table lookup
//  into the result register. One item per cycle while rsp_ready does not stall it.
//  req_ready drops only when both stages hold items and rsp_ready is low.
//  Reset clears both stage valids; payload registers are not reset.
// ----------------------------------------------------------------------------
module id_register_read_emulation (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [idre_pkg::InsnWidth-1:0]  req_insn_word,
   input  logic [idre_pkg::ValueWidth-1:0] req_raw_id_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_handled,
   output logic [idre_pkg::RegWidth-1:0]   rsp_dest_reg,
   output logic [idre_pkg::ValueWidth-1:0] rsp_read_value
);
   import idre_pkg::*;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [InsnWidth-1:0]  insn_ff;
   logic [ValueWidth-1:0] raw_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   result_type            out_ff;
   result_type            dec_result;
   logic                  out_take;
   logic                  in_take;

   // result register frees up when empty or drained this cycle
   assign out_take  = !out_valid_ff || rsp_ready;
   assign in_take   = !in_valid_ff || out_take;
   assign req_ready = in_take;

   assign in_valid_in  = in_take ? req_valid : in_valid_ff;
   assign out_valid_in = out_take ? in_valid_ff : out_valid_ff;

   idre_decode u_decode (
      .insn_word    (insn_ff),
      .raw_id_value (raw_ff),
      .result       (dec_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && req_valid) begin
         insn_ff <= req_insn_word;
         raw_ff  <= req_raw_id_value;
      end
      if (out_take && in_valid_ff) begin
         out_ff <= dec_result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_handled    = out_ff.handled;
   assign rsp_dest_reg   = out_ff.dest_reg;
   assign rsp_read_value = out_ff.read_value;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_valid_ff)
      else $error("accepted item not held in input register");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_take |=> out_valid_ff)
      else $error("item lost between input and result register");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.handled |-> out_ff.dest_reg == '0 && out_ff.read_value == '0)
      else $error("refused item carries nonzero fields");

   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stalls with empty input register");

endmodule
